// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: design/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// Free page stack allocator package
// Sizes, codes and shared types of the page allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int unsigned MAX_PAGES  = 32768;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FREE_W     = 16;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CUR_W      = PAGE_W + 1;
  localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [PAGE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

// File: design/free_page_stack_allocator_top.sv
// ----------------------------------------------------------------------------
// Free page stack allocator
// LIFO stack of free physical page numbers with init, alloc and free actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries an action and a page address.
//   Output channel (out_valid_o/out_ready_i) returns one result per item:
//   granted address, status and free-page count after the action.
//   Limits are written through cfg_we_i/cfg_index_i/cfg_data_i while idle.
// Sequencing:
//   free, empty alloc and unused codes: S_DONE, then the output register.
//   alloc with a page: S_POP waits on the registered read of the stack memory, then S_DONE.
//   init: S_INIT writes one page per cycle into the memory, at most MAX_PAGES
//   pushes, then S_DONE.
//   One item is in flight at a time; the next is accepted once the previous
//   result sits in the output register.
// Reset:
//   Stack is empty, limits take their reset values; memory is not cleared,
//   entries are only read below the count.
// Stall:
//   A held result keeps its register; a finished item waits until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module free_page_stack_allocator_top import fpsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [ADDR_W-1:0] page_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [1:0]        status_o,
  output logic [FREE_W-1:0] free_pages_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_POP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] low_limit_q, low_limit_d;
  logic [ADDR_W-1:0] high_limit_q, high_limit_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  status_e           out_status_q, out_status_d;
  logic [FREE_W-1:0] out_free_q, out_free_d;

  ram_req_t          ram_req;
  logic [PAGE_W-1:0] ram_rdata;
  logic              in_accept;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CUR_W-1:0]  first_page;
  logic [CUR_W-1:0]  high_page;
  logic              bad_addr;

  fpsa_page_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign cnt_dec    = count_q - CNT_W'(1);
  assign cnt_inc    = count_q + CNT_W'(1);
  assign first_page = CUR_W'(low_limit_q[ADDR_W-1:PAGE_SHIFT])
                    + CUR_W'(|low_limit_q[PAGE_SHIFT-1:0]);
  assign high_page  = CUR_W'(high_limit_q[ADDR_W-1:PAGE_SHIFT]);
  assign bad_addr   = (|page_address_i[PAGE_SHIFT-1:0]) || (page_address_i < low_limit_q)
                    || (page_address_i >= high_limit_q);

  always_comb begin
    low_limit_d  = low_limit_q;
    high_limit_d = high_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOW_LIMIT:  low_limit_d  = cfg_data_i;
        CFG_HIGH_LIMIT: high_limit_d = cfg_data_i;
        default:        low_limit_d  = low_limit_q;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_free_d   = out_free_q;
    ram_req      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_addr_d   = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          case (action_i)
            ACT_INIT: begin
              count_d  = '0;
              cursor_d = first_page;
              state_d  = S_INIT;
            end
            ACT_ALLOC: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                count_d       = cnt_dec;
                ram_req.re    = 1'b1;
                ram_req.raddr = cnt_dec[IDX_W-1:0];
                state_d       = S_POP;
              end
            end
            ACT_FREE: begin
              if (bad_addr) begin
                res_status_d = ST_BAD;
              end else if (count_q >= MAX_CNT) begin
                res_status_d = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_q[IDX_W-1:0];
                ram_req.wdata = page_address_i[ADDR_W-1:PAGE_SHIFT];
                count_d       = cnt_inc;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end
      S_INIT: begin
        if (cursor_q < high_page) begin
          if (count_q >= MAX_CNT) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = count_q[IDX_W-1:0];
            ram_req.wdata = cursor_q[PAGE_W-1:0];
            count_d       = cnt_inc;
            cursor_d      = cursor_q + CUR_W'(1);
          end
        end else begin
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end
      end
      S_POP: begin
        res_addr_d = {ram_rdata, {PAGE_SHIFT{1'b0}}};
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          out_free_d   = FREE_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      low_limit_q  <= 32'h8000_0000;
      high_limit_q <= 32'h8800_0000;
      count_q      <= '0;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      low_limit_q  <= low_limit_d;
      high_limit_q <= high_limit_d;
      count_q      <= count_d;
      cursor_q     <= cursor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;
  assign free_pages_o      = out_free_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > MAX_CNT, "stack count above capacity")
  `ASSERT_PROP(a_pop_dec, clk_i, rst_ni, (in_accept && action_i == ACT_ALLOC && count_q != '0) |=> (count_q == $past(cnt_dec)), "pop did not decrement count")
  `ASSERT_NEVER(a_empty_zero, clk_i, rst_ni, out_valid_q && out_status_q == ST_EMPTY && out_addr_q != '0, "empty result with nonzero address")

endmodule

// File: design/fpsa_page_ram.sv
// ----------------------------------------------------------------------------
// Page stack memory
// One write and one registered read port holding free page numbers.
// ----------------------------------------------------------------------------
module fpsa_page_ram import fpsa_pkg::*; (
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [PAGE_W-1:0] rdata_o
);

  logic [PAGE_W-1:0] mem [MAX_PAGES];
  logic [PAGE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/tb_free_page_stack_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page stack allocator testbench
// Drives init, alloc and free items through the valid/ready channels and
// rewrites the memory limits between phases while the block is idle. Every
// item's result is predicted in step with acceptance. Each returned result is
// compared field by field against the oldest prediction. The stimulus opens
// with directed corner cases, including full-stack inits at both extremes of
// the limits. It goes on with random phases over small page ranges, each
// phase mostly a well-formed mix of init, alloc and free of granted pages.
// ----------------------------------------------------------------------------
module tb_free_page_stack_allocator_top;
  import fpsa_pkg::*;

  localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'(PAGE_BYTES - 1);

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    status_e           status;
    logic [FREE_W-1:0] free_pages;
  } page_result_t;

  class page_stack_scoreboard;
    logic [PAGE_W-1:0] page_stack [MAX_PAGES];
    int unsigned       page_count;
    logic [ADDR_W-1:0] low_limit;
    logic [ADDR_W-1:0] high_limit;
    page_result_t      expected_results [$];
    int unsigned       failures;

    function new();
      page_count = 0;
      low_limit  = 32'h8000_0000;
      high_limit = 32'h8800_0000;
      failures   = 0;
    endfunction

    function void set_limits(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      low_limit  = lo;
      high_limit = hi;
    endfunction

    function status_e fill_from_limits();
      longint unsigned cursor;
      longint unsigned top;
      status_e         st;
      cursor = {32'd0, low_limit};
      cursor = ((cursor + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
      top = {32'd0, high_limit};
      st = ST_OK;
      page_count = 0;
      while (cursor + PAGE_BYTES <= top && st == ST_OK) begin
        if (page_count >= MAX_PAGES) begin
          st = ST_FULL;
        end else begin
          page_stack[page_count] = PAGE_W'(cursor >> PAGE_SHIFT);
          page_count++;
          cursor += PAGE_BYTES;
        end
      end
      return st;
    endfunction

    function page_result_t note_item(action_e act, logic [ADDR_W-1:0] addr);
      page_result_t res;
      res.granted = '0;
      res.status  = ST_OK;
      case (act)
        ACT_INIT: begin
          res.status = fill_from_limits();
        end
        ACT_ALLOC: begin
          if (page_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            page_count--;
            res.granted = ADDR_W'(page_stack[page_count]) << PAGE_SHIFT;
          end
        end
        ACT_FREE: begin
          if ((addr & OFFSET_MASK) != 0 || addr < low_limit || addr >= high_limit) begin
            res.status = ST_BAD;
          end else if (page_count >= MAX_PAGES) begin
            res.status = ST_FULL;
          end else begin
            page_stack[page_count] = PAGE_W'(addr >> PAGE_SHIFT);
            page_count++;
          end
        end
        default: ;
      endcase
      res.free_pages = FREE_W'(page_count);
      expected_results.push_back(res);
      return res;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [ADDR_W-1:0] granted, logic [1:0] status,
                               logic [FREE_W-1:0] free_pages);
      page_result_t exp;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with no item pending: addr %08h status %0d free %0d",
                               granted, status, free_pages));
        return;
      end
      exp = expected_results.pop_front();
      if (granted !== exp.granted || status !== exp.status || free_pages !== exp.free_pages)
        note_failure($sformatf(
          "mismatch: expected addr %08h status %0d free %0d, got addr %08h status %0d free %0d",
          exp.granted, exp.status, exp.free_pages, granted, status, free_pages));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_LOW_LIMIT;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  action_e           in_action = ACT_NONE;
  logic [ADDR_W-1:0] in_addr = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [1:0]        status;
  logic [FREE_W-1:0] free_pages;

  page_stack_scoreboard sb = new();
  logic [ADDR_W-1:0]    held_pages [$];
  int unsigned          items_sent = 0;
  int unsigned          tx_idle_pct = 19;
  int unsigned          rx_idle_pct = 77;

  free_page_stack_allocator_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (in_action),
    .page_address_i   (in_addr),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .granted_address_o(granted_address),
    .status_o         (status),
    .free_pages_o     (free_pages)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(granted_address, status, free_pages);
  end

  task automatic send_item(input action_e act, input logic [ADDR_W-1:0] addr);
    page_result_t res;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_addr   <= addr;
    do @(posedge clk_i); while (!in_ready);
    res = sb.note_item(act, addr);
    if (act == ACT_INIT) held_pages.delete();
    if (act == ACT_ALLOC && res.status == ST_OK) held_pages.push_back(res.granted);
    items_sent++;
    tx_idle_pct = (items_sent < 325) ? 19 : (items_sent < 650) ? 77 : 0;
    rx_idle_pct = (items_sent < 325) ? 77 : (items_sent < 650) ? 19 : 0;
  endtask

  // hold off until every predicted result has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_LIMIT;
    cfg_data  <= lo;
    @(posedge clk_i);
    cfg_index <= CFG_HIGH_LIMIT;
    cfg_data  <= hi;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_limits(lo, hi);
  endtask

  initial begin : stimulus
    int unsigned       random_items;
    int unsigned       phase_len;
    int unsigned       pick;
    int unsigned       k;
    int                idx;
    action_e           act;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo_round;
    logic [ADDR_W-1:0] addr;

    random_items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: fills the stack exactly
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_FREE, 32'h8000_0001);
    send_item(ACT_FREE, 32'h8000_0000);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_INIT, 32'h0);
    send_item(ACT_FREE, 32'h87FF_F000);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_FREE, 32'h8800_0000);
    send_item(ACT_FREE, 32'h7FFF_F000);
    drain_results();

    // widest range: init stops on a full stack
    write_limits(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_INIT, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_FREE, 32'hFFFF_F000);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_FREE, 32'hFFFF_FFFF);
    send_item(ACT_FREE, 32'h0000_0000);
    send_item(ACT_FREE, 32'h0000_1000);
    drain_results();

    // inverted limits leave nothing to fill
    write_limits(32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_INIT, 32'h0);
    send_item(ACT_FREE, 32'hFFFF_F000);
    drain_results();

    // unaligned low limit, one page, double free
    write_limits(32'h0000_1001, 32'h0000_3000);
    send_item(ACT_INIT, 32'h0);
    send_item(ACT_FREE, 32'h0000_1000);
    send_item(ACT_FREE, 32'h0000_2000);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_ALLOC, 32'h0);
    send_item(ACT_ALLOC, 32'h0);

    while (random_items < 950) begin
      drain_results();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        lo = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
        write_limits(lo, 32'hFFFF_FFFF);
      end else if (pick >= 2) begin
        lo = $urandom & 32'hFFF0_0000;
        if ($urandom_range(0, 2) == 0) lo = lo | $urandom_range(1, PAGE_BYTES - 1);
        hi = ((lo + OFFSET_MASK) & ~OFFSET_MASK) + $urandom_range(0, 48) * PAGE_BYTES;
        if ($urandom_range(0, 3) == 0) hi = hi + $urandom_range(1, PAGE_BYTES - 1);
        if (pick == 2) write_limits(hi, lo);
        else write_limits(lo, hi);
      end
      if (pick != 1 || $urandom_range(0, 1) == 0) begin
        send_item(ACT_INIT, $urandom);
        random_items++;
      end
      phase_len = $urandom_range(8, 40);
      for (k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        lo_round = (sb.low_limit + OFFSET_MASK) & ~OFFSET_MASK;
        act = ACT_ALLOC;
        addr = $urandom;
        if (pick >= 40 && pick < 70 && held_pages.size() != 0) begin
          act = ACT_FREE;
          idx = $urandom_range(0, held_pages.size() - 1);
          addr = held_pages[idx];
          held_pages.delete(idx);
        end else if (pick >= 70 && pick < 77) begin
          act = ACT_FREE;
          addr = lo_round + $urandom_range(0, 48) * PAGE_BYTES;
        end else if (pick >= 77 && pick < 87) begin
          act = ACT_FREE;
          case ($urandom_range(0, 2))
            0:       addr = (lo_round + $urandom_range(0, 48) * PAGE_BYTES)
                            | $urandom_range(1, PAGE_BYTES - 1);
            1:       addr = (sb.low_limit - 1) & ~OFFSET_MASK;
            default: addr = sb.high_limit;
          endcase
        end else if (pick >= 87 && pick < 92) begin
          act = ACT_NONE;
        end else if (pick >= 92 && pick < 95) begin
          act = ACT_INIT;
        end else if (pick >= 95) begin
          act = ACT_FREE;
        end
        send_item(act, addr);
        if (act != ACT_NONE) random_items++;
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
